[hw/rtl/cdiv_pkg.sv]
// cdiv_pkg: shared types and constants for the complex divider
// holds the port item structs and the pipeline stage records; depends on nothing

package cdiv_pkg;

	// field width of every operand and quotient part
	localparam int DATA_W = 16;

	// start-to-done path: four front stages, one per quotient bit, one output stage
	localparam int LATENCY = DATA_W + 5;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] num_re;
		logic signed [DATA_W-1:0] num_im;
		logic signed [DATA_W-1:0] den_re;
		logic signed [DATA_W-1:0] den_im;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quot_re;
		logic signed [DATA_W-1:0] quot_im;
		logic                     zero_divisor;
		logic                     saturated;
	} out_t;

	// data that rides alongside the division untouched
	typedef struct packed {
		logic              zero_div;
		logic [DATA_W-1:0] pass_re;
		logic [DATA_W-1:0] pass_im;
	} side_t;

	// one quotient lane of the restoring divider
	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic [2*DATA_W-1:0] rem;
		logic [DATA_W-1:0]   mbits;
		logic [DATA_W-1:0]   quo;
	} lane_t;

	typedef struct packed {
		side_t               side;
		logic [2*DATA_W-1:0] den;
		lane_t               re;
		lane_t               im;
	} stage_t;

endpackage

[hw/rtl/cdiv_front.sv]
// cdiv_front: products, sums, magnitudes and divider setup (four register stages)
// depends on cdiv_pkg

module cdiv_front #(
	parameter int FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cdiv_pkg::in_t        operand,
	output logic                 next_valid,
	output cdiv_pkg::stage_t     next_stage
);

	localparam int W  = cdiv_pkg::DATA_W;
	localparam int PW = 2 * W;
	localparam int MW = PW + FRAC_BITS;
	localparam int HW = W + FRAC_BITS;
	localparam int CW = (HW > PW) ? HW : PW;

	// stage 1: six products
	logic                 v_s1;
	logic signed [PW-1:0] ac_s1, bd_s1, bc_s1, ad_s1, cc_s1, dd_s1;
	cdiv_pkg::side_t      side_s1;

	// stage 2: numerators and divisor
	logic                 v_s2;
	logic signed [PW:0]   nre_s2, nim_s2;
	logic [PW-1:0]        den_s2;
	cdiv_pkg::side_t      side_s2;

	// stage 3: sign and magnitude
	logic                 v_s3;
	logic                 neg_re_s3, neg_im_s3;
	logic [PW-1:0]        mag_re_s3, mag_im_s3;
	logic [PW-1:0]        den_s3;
	cdiv_pkg::side_t      side_s3;

	function automatic cdiv_pkg::lane_t init_lane(logic neg, logic [PW-1:0] mag,
			logic [PW-1:0] den);
		logic [MW-1:0]   m;
		logic [HW-1:0]   hi;
		cdiv_pkg::lane_t l;
		m       = MW'(mag) << FRAC_BITS;
		hi      = m[MW-1:W];
		l.neg   = neg;
		l.ovf   = (CW'(hi) >= CW'(den));
		l.rem   = PW'(hi);
		l.mbits = m[W-1:0];
		l.quo   = '0;
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			next_valid <= 1'b0;
		end else begin
			v_s1       <= start;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			next_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ac_s1            <= $signed(operand.num_re) * $signed(operand.den_re);
		bd_s1            <= $signed(operand.num_im) * $signed(operand.den_im);
		bc_s1            <= $signed(operand.num_im) * $signed(operand.den_re);
		ad_s1            <= $signed(operand.num_re) * $signed(operand.den_im);
		cc_s1            <= $signed(operand.den_re) * $signed(operand.den_re);
		dd_s1            <= $signed(operand.den_im) * $signed(operand.den_im);
		side_s1.zero_div <= (operand.den_re == '0) && (operand.den_im == '0);
		side_s1.pass_re  <= operand.num_re;
		side_s1.pass_im  <= operand.num_im;

		nre_s2  <= (PW+1)'(ac_s1) + (PW+1)'(bd_s1);
		nim_s2  <= (PW+1)'(bc_s1) - (PW+1)'(ad_s1);
		den_s2  <= $unsigned(cc_s1) + $unsigned(dd_s1);
		side_s2 <= side_s1;

		neg_re_s3 <= nre_s2[PW];
		neg_im_s3 <= nim_s2[PW];
		mag_re_s3 <= nre_s2[PW] ? PW'(-nre_s2) : PW'(nre_s2);
		mag_im_s3 <= nim_s2[PW] ? PW'(-nim_s2) : PW'(nim_s2);
		den_s3    <= den_s2;
		side_s3   <= side_s2;

		next_stage.side <= side_s3;
		next_stage.den  <= den_s3;
		next_stage.re   <= init_lane(neg_re_s3, mag_re_s3, den_s3);
		next_stage.im   <= init_lane(neg_im_s3, mag_im_s3, den_s3);
	end

endmodule

[hw/rtl/cdiv_bit.sv]
// cdiv_bit: one restoring-division step for both quotient lanes, registered
// depends on cdiv_pkg

module cdiv_bit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             prev_valid,
	input  cdiv_pkg::stage_t prev_stage,
	output logic             next_valid,
	output cdiv_pkg::stage_t next_stage
);

	localparam int W  = cdiv_pkg::DATA_W;
	localparam int PW = 2 * W;

	function automatic cdiv_pkg::lane_t step(cdiv_pkg::lane_t l, logic [PW-1:0] den);
		logic [PW:0]     t;
		logic [PW:0]     diff;
		logic            ge;
		cdiv_pkg::lane_t r;
		t       = {l.rem, l.mbits[W-1]};
		diff    = t - {1'b0, den};
		ge      = (t >= {1'b0, den});
		r       = l;
		r.rem   = ge ? diff[PW-1:0] : t[PW-1:0];
		r.mbits = {l.mbits[W-2:0], 1'b0};
		r.quo   = {l.quo[W-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_valid <= 1'b0;
		end else begin
			next_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		next_stage.side <= prev_stage.side;
		next_stage.den  <= prev_stage.den;
		next_stage.re   <= step(prev_stage.re, prev_stage.den);
		next_stage.im   <= step(prev_stage.im, prev_stage.den);
	end

endmodule

[hw/rtl/cdiv_sat.sv]
// cdiv_sat: clipping, sign restore and zero-divisor bypass into the result register
// depends on cdiv_pkg

module cdiv_sat (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             prev_valid,
	input  cdiv_pkg::stage_t prev_stage,
	output logic             done,
	output cdiv_pkg::out_t   result
);

	localparam int W = cdiv_pkg::DATA_W;

	logic         over_re, over_im;
	logic [W-1:0] q_re, q_im;

	// quotient too large for the signed range (one more allowed when negative)
	function automatic logic too_big(cdiv_pkg::lane_t l);
		return l.ovf || (l.quo[W-1] && (!l.neg || (l.quo[W-2:0] != '0)));
	endfunction

	function automatic logic [W-1:0] finish(cdiv_pkg::lane_t l, logic over);
		logic [W-1:0] mag;
		mag = over ? (l.neg ? cdiv_pkg::SAT_MIN : cdiv_pkg::SAT_MAX) : l.quo;
		return l.neg ? W'(-mag) : mag;
	endfunction

	always_comb begin
		over_re = too_big(prev_stage.re);
		over_im = too_big(prev_stage.im);
		q_re    = finish(prev_stage.re, over_re);
		q_im    = finish(prev_stage.im, over_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_stage.side.zero_div) begin
			result.quot_re   <= prev_stage.side.pass_re;
			result.quot_im   <= prev_stage.side.pass_im;
			result.saturated <= 1'b0;
		end else begin
			result.quot_re   <= q_re;
			result.quot_im   <= q_im;
			result.saturated <= over_re || over_im;
		end
		result.zero_divisor <= prev_stage.side.zero_div;
	end

endmodule

[hw/rtl/complex_divider_top.sv]
// complex_divider_top: pipelined Cartesian complex divider, fixed point
// depends on cdiv_pkg, cdiv_front, cdiv_bit, cdiv_sat

// Divides (num_re + j num_im) by (den_re + j den_im), all signed 16-bit fixed point
// with FRAC_BITS fraction bits. Each quotient part is the exact value truncated toward
// zero and clipped to the 16-bit signed range; saturated flags any clipping. A zero
// divisor passes the numerator through and raises zero_divisor. The block takes one
// item every clock: busy is always low, so start may be held high continuously.
// Every item gives one result after passing 4 front stages (products, sums and divider
// setup), one stage per quotient bit and one output stage.
// Results are shown for one clock with done high; the receiver cannot stall the block
// and must take each result in that cycle.

module complex_divider_top #(
	parameter int FRAC_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cdiv_pkg::in_t  operand,
	output logic           done,
	output cdiv_pkg::out_t result
);

	localparam int W = cdiv_pkg::DATA_W;

	// pipe[0] comes out of the front end, pipe[k+1] after quotient bit k
	logic             pipe_valid [0:W];
	cdiv_pkg::stage_t pipe       [0:W];

	// the pipeline never holds off an item
	assign busy = 1'b0;

	// products, sums, magnitudes and overflow check
	cdiv_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operand   (operand),
		.next_valid(pipe_valid[0]),
		.next_stage(pipe[0])
	);

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < W; k++) begin : g_bit
		cdiv_bit u_bit (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_valid(pipe_valid[k]),
			.prev_stage(pipe[k]),
			.next_valid(pipe_valid[k+1]),
			.next_stage(pipe[k+1])
		);
	end

	// clip, restore sign, bypass on zero divisor
	cdiv_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.prev_valid(pipe_valid[W]),
		.prev_stage(pipe[W]),
		.done      (done),
		.result    (result)
	);

endmodule

[hw/rtl/cdiv_checker.sv]
// cdiv_checker: port-level checks of the complex divider, bound to the top level
// depends on cdiv_pkg and complex_divider_top

module cdiv_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input cdiv_pkg::in_t  operand,
	input logic           done,
	input cdiv_pkg::out_t result
);

	localparam int LAT = cdiv_pkg::LATENCY;

	// every accepted item comes back after the fixed latency
	a_item_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not produce a result on time");

	// no result without an item accepted the latency before
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching item");

	// zero divisor passes the numerator of that item through, unclipped
	a_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_divisor) |->
			(result.quot_re == $past(operand.num_re, LAT)) &&
			(result.quot_im == $past(operand.num_im, LAT)) && !result.saturated)
		else $error("zero divisor bypass wrong");

	// a clipped result sits on a range limit in at least one part
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.quot_re == cdiv_pkg::SAT_MAX) || (result.quot_re == cdiv_pkg::SAT_MIN) ||
			(result.quot_im == cdiv_pkg::SAT_MAX) || (result.quot_im == cdiv_pkg::SAT_MIN))
		else $error("saturated flag without a clipped part");

endmodule

bind complex_divider_top cdiv_checker u_cdiv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.operand(operand),
	.done   (done),
	.result (result)
);

[tb/complex_divider_top_tb.sv]
// complex_divider_top_tb: self-checking bench for the pipelined complex divider
// drives operand items through start/busy and checks every done strobe against a predictor
// depends on cdiv_pkg and complex_divider_top

module complex_divider_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdiv_pkg::*;

	localparam int FRAC_BITS       = 12;
	localparam int ITEMS_PER_PHASE = 550;
	localparam int SETTLE_CYCLES   = LATENCY + 8;
	localparam int REPORT_LIMIT    = 10;

	// handy fixed-point operand values
	localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] MONE = DATA_W'(-(1 << FRAC_BITS));
	localparam logic signed [DATA_W-1:0] MAXV = SAT_MAX;
	localparam logic signed [DATA_W-1:0] MINV = SAT_MIN;
	localparam logic signed [DATA_W-1:0] LSBN = '1;

	// expected quotients in order of acceptance, plus the failure count
	class quotient_board;
		out_t quot_queue[$];
		int   failures = 0;

		// one quotient part: exact sum over |divisor|^2, truncated toward zero, then clipped
		function logic [DATA_W-1:0] scaled_part(longint num, longint den_sq, output bit clip);
			longint mag;
			longint q;
			longint limit;
			bit     neg;
			neg   = num < 0;
			mag   = neg ? -num : num;
			q     = (mag << FRAC_BITS) / den_sq;
			limit = (longint'(1) << (DATA_W - 1)) - longint'(!neg);
			clip  = q > limit;
			if (clip)
				q = limit;
			if (neg)
				q = -q;
			return q[DATA_W-1:0];
		endfunction

		function out_t divide_complex(in_t v);
			longint a, b, c, d, den_sq;
			bit     clip_re, clip_im;
			out_t   r;
			a = longint'(v.num_re);
			b = longint'(v.num_im);
			c = longint'(v.den_re);
			d = longint'(v.den_im);
			if (c == 0 && d == 0) begin
				// zero divisor: numerator passes straight through
				r.quot_re      = v.num_re;
				r.quot_im      = v.num_im;
				r.zero_divisor = 1'b1;
				r.saturated    = 1'b0;
				return r;
			end
			den_sq         = c * c + d * d;
			r.quot_re      = scaled_part(a * c + b * d, den_sq, clip_re);
			r.quot_im      = scaled_part(b * c - a * d, den_sq, clip_im);
			r.zero_divisor = 1'b0;
			r.saturated    = clip_re | clip_im;
			return r;
		endfunction

		function void note_operands(in_t v);
			quot_queue.push_back(divide_complex(v));
		endfunction

		function void check_quotient(out_t got);
			out_t want;
			if (quot_queue.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result with nothing pending: re=%h im=%h zd=%b sat=%b",
						$realtime, got.quot_re, got.quot_im, got.zero_divisor, got.saturated);
				return;
			end
			want = quot_queue.pop_front();
			if (got.quot_re !== want.quot_re || got.quot_im !== want.quot_im ||
					got.zero_divisor !== want.zero_divisor || got.saturated !== want.saturated) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: mismatch exp re=%h im=%h zd=%b sat=%b, got re=%h im=%h zd=%b sat=%b",
						$realtime, want.quot_re, want.quot_im, want.zero_divisor, want.saturated,
						got.quot_re, got.quot_im, got.zero_divisor, got.saturated);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	in_t  operand;
	out_t result;

	quotient_board board = new();

	always #5ns clk = ~clk;

	complex_divider_top #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.operand (operand),
		.done    (done),
		.result  (result)
	);

	// monitor: everything sampled on the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_operands(operand);
			if (done)
				board.check_quotient(result);
		end
	end

	// one operand part: extremes, small values up to unity in magnitude, or anything at all
	function automatic logic [DATA_W-1:0] random_part();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(6))
					0: return MINV;
					1: return MAXV;
					2: return '0;
					3: return 16'd1;
					4: return LSBN;
					5: return ONE;
					default: return MONE;
				endcase
			end
			1, 2: return 16'($urandom_range(2 * 4096)) - 16'd4096;
			3:    return 16'($urandom_range(255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_t random_operands();
		in_t v;
		v.num_re = random_part();
		v.num_im = random_part();
		v.den_re = random_part();
		v.den_im = random_part();
		// zero divisors and purely real or imaginary divisors get extra weight
		case ($urandom_range(15))
			0: begin
				v.den_re = '0;
				v.den_im = '0;
			end
			1: v.den_re = '0;
			2: v.den_im = '0;
			default: ;
		endcase
		return v;
	endfunction

	// entered and left on a falling edge; idles the sender with the given chance per cycle
	task automatic send_item(in_t v, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		operand <= v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// hold the sender off until every pending quotient has come back
	task automatic wait_for_quotients();
		start <= 1'b0;
		do
			@(negedge clk);
		while (board.quot_queue.size() != 0);
	endtask

	task automatic send_random_phase(int idle_pct);
		repeat (ITEMS_PER_PHASE)
			send_item(random_operands(), idle_pct);
		wait_for_quotients();
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		operand = '0;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero divisor with extreme and zero numerators
		send_item(in_t'{MINV, MAXV, '0, '0}, 0);
		send_item(in_t'{MAXV, MINV, '0, '0}, 0);
		send_item(in_t'{'0, '0, '0, '0}, 0);
		// unit divisors: one, minus one, j, minus j
		send_item(in_t'{16'sh1234, 16'shDCBA, ONE, '0}, 0);
		send_item(in_t'{MINV, MAXV, MONE, '0}, 0);
		send_item(in_t'{ONE, ONE + ONE, '0, ONE}, 0);
		send_item(in_t'{ONE, '0, '0, MONE}, 0);
		// most negative quotient reached exactly, no clipping
		send_item(in_t'{MINV, '0, ONE, '0}, 0);
		// smallest divisors, some clipping high and low
		send_item(in_t'{MAXV, MAXV, 16'sd1, '0}, 0);
		send_item(in_t'{MINV, MINV, '0, 16'sd1}, 0);
		send_item(in_t'{16'sd1, LSBN, 16'sd1, 16'sd1}, 0);
		send_item(in_t'{LSBN, LSBN, LSBN, LSBN}, 0);
		// largest divisors
		send_item(in_t'{MAXV, MAXV, MINV, MINV}, 0);
		send_item(in_t'{MINV, MINV, MINV, MINV}, 0);
		send_item(in_t'{MAXV, MINV, MAXV, MINV}, 0);
		send_item(in_t'{MAXV, '0, '0, MINV}, 0);
		send_item(in_t'{16'sd1, 16'sd1, MAXV, '0}, 0);
		// zero numerator over a nonzero divisor
		send_item(in_t'{'0, '0, 16'sh7001, 16'shD000}, 0);
		// truncation toward zero on negative quotients
		send_item(in_t'{LSBN, '0, 16'sh3000, '0}, 0);
		send_item(in_t'{MONE, '0, 16'sh3000, '0}, 0);
		send_item(in_t'{MINV, MAXV, ONE + ONE, ONE + ONE}, 0);
		wait_for_quotients();

		// busy sender, then a sparse one, then back to back
		send_random_phase(28);
		send_random_phase(56);
		send_random_phase(0);

		// let any stray result show up before judging
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (board.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/cdiv_pkg.sv
hw/rtl/cdiv_front.sv
hw/rtl/cdiv_bit.sv
hw/rtl/cdiv_sat.sv
hw/rtl/complex_divider_top.sv
hw/rtl/cdiv_checker.sv
tb/complex_divider_top_tb.sv
